>>> src/ufg_pkg.sv
// Package for the UDP frame generator: frame layout constants, the queue entry and
// configuration bundle types, and the ones' complement fold helper.
// Depends on nothing; every other file in src uses it.
package ufg_pkg;

  localparam int LenW           = 11;
  localparam int MaxFrameBytes  = 1514;
  localparam int MinFrameBytes  = 46;
  localparam int QueueDepth     = 2;

  localparam logic [LenW-1:0] ResetFrameLength = 11'd60;

  // Byte offsets of the header fields.
  localparam logic [LenW-1:0] OffSrcMac   = 11'd6;
  localparam logic [LenW-1:0] OffEthType  = 11'd12;
  localparam logic [LenW-1:0] OffIpLen    = 11'd16;
  localparam logic [LenW-1:0] OffIpFlags  = 11'd20;
  localparam logic [LenW-1:0] OffIpTtl    = 11'd22;
  localparam logic [LenW-1:0] OffIpProto  = 11'd23;
  localparam logic [LenW-1:0] OffIpSum    = 11'd24;
  localparam logic [LenW-1:0] OffSrcIp    = 11'd26;
  localparam logic [LenW-1:0] OffDstIp    = 11'd30;
  localparam logic [LenW-1:0] OffPorts    = 11'd34;
  localparam logic [LenW-1:0] OffUdpLen   = 11'd38;
  localparam logic [LenW-1:0] OffUdpSum   = 11'd40;
  localparam logic [LenW-1:0] OffPayload  = 11'd42;
  localparam logic [LenW-1:0] EthHdrBytes = 11'd14;
  localparam logic [LenW-1:0] EthIpBytes  = 11'd34;

  // Protocol constants.
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  IpVerIhl      = 8'h45;
  localparam logic [7:0]  TosLowDelay   = 8'h10;
  localparam logic [15:0] DontFragment  = 16'h4000;
  localparam logic [7:0]  DefaultTtl    = 8'd64;
  localparam logic [7:0]  UdpProto      = 8'd17;
  // Fixed IPv4 header words summed together: ver/ihl/tos, flags, ttl/proto.
  localparam logic [19:0] IpFixedSum    = 20'h0C521;

  // Configuration register indexes.
  localparam logic [2:0] CfgDstMac   = 3'd0;
  localparam logic [2:0] CfgSrcMac   = 3'd1;
  localparam logic [2:0] CfgDstIp    = 3'd2;
  localparam logic [2:0] CfgSrcIp    = 3'd3;
  localparam logic [2:0] CfgPorts    = 3'd4;
  localparam logic [2:0] CfgFrameLen = 3'd5;
  localparam logic [2:0] CfgSeed     = 3'd6;
  localparam logic [2:0] CfgCsumOn   = 3'd7;

  typedef enum logic [3:0] {
    RegDstMac,
    RegSrcMac,
    RegConst,
    RegIpLen,
    RegIpSum,
    RegSrcIp,
    RegDstIp,
    RegPorts,
    RegUdpLen,
    RegUdpSum,
    RegPayload
  } region_e;

  typedef struct packed {
    region_e         region;
    logic [2:0]      sel;
    logic [7:0]      cbyte;
    logic [LenW-1:0] offset;
    logic            last;
  } entry_t;

  typedef struct packed {
    logic [47:0]     dst_mac;
    logic [47:0]     src_mac;
    logic [31:0]     dst_ip;
    logic [31:0]     src_ip;
    logic [31:0]     ports;
    logic [31:0]     seed;
    logic            csum_on;
    logic [LenW-1:0] len;
  } cfg_t;

  // End-around-carry fold of a sum down to 16 bits. Two folds are enough for
  // any 28-bit input: the first leaves at most 0x10FFE, the second at most 0xFFFF.
  function automatic logic [15:0] fold16(input logic [27:0] x);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = 17'(x[27:16]) + 17'(x[15:0]);
    s2 = 17'(s1[16]) + 17'(s1[15:0]);
    return s2[15:0];
  endfunction

endpackage

>>> src/ufg_front.sv
// Front end of the UDP frame generator: accepts request beats, tracks the
// byte position and classifies each byte into a field of the frame.
// Depends on ufg_pkg.
module ufg_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       restart_i,
  input  logic [ufg_pkg::LenW-1:0]   len_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output ufg_pkg::entry_t            push_data_o
);

  logic [ufg_pkg::LenW-1:0] pos_q, pos_d;
  logic [ufg_pkg::LenW-1:0] p;
  logic [ufg_pkg::LenW:0]   p_inc;
  logic                     last;
  ufg_pkg::region_e         region;
  logic [ufg_pkg::LenW-1:0] rel;
  logic [7:0]               cbyte;

  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    p     = (restart_i || (pos_q >= len_i)) ? '0 : pos_q;
    p_inc = {1'b0, p} + 12'd1;
    last  = (p_inc == {1'b0, len_i});
    pos_d = (p_inc >= {1'b0, len_i}) ? '0 : p_inc[ufg_pkg::LenW-1:0];
  end

  // Field classification by byte offset.
  always_comb begin
    cbyte = 8'h00;
    if (p < ufg_pkg::OffSrcMac) begin
      region = ufg_pkg::RegDstMac;
      rel    = p;
    end else if (p < ufg_pkg::OffEthType) begin
      region = ufg_pkg::RegSrcMac;
      rel    = p - ufg_pkg::OffSrcMac;
    end else if (p >= ufg_pkg::OffPayload) begin
      region = ufg_pkg::RegPayload;
      rel    = p - ufg_pkg::OffPayload;
    end else if (p >= ufg_pkg::OffSrcIp && p < ufg_pkg::OffDstIp) begin
      region = ufg_pkg::RegSrcIp;
      rel    = p - ufg_pkg::OffSrcIp;
    end else if (p >= ufg_pkg::OffDstIp && p < ufg_pkg::OffPorts) begin
      region = ufg_pkg::RegDstIp;
      rel    = p - ufg_pkg::OffDstIp;
    end else if (p >= ufg_pkg::OffPorts && p < ufg_pkg::OffUdpLen) begin
      region = ufg_pkg::RegPorts;
      rel    = p - ufg_pkg::OffPorts;
    end else if (p >= ufg_pkg::OffUdpLen && p < ufg_pkg::OffUdpSum) begin
      region = ufg_pkg::RegUdpLen;
      rel    = p - ufg_pkg::OffUdpLen;
    end else if (p >= ufg_pkg::OffUdpSum) begin
      region = ufg_pkg::RegUdpSum;
      rel    = p - ufg_pkg::OffUdpSum;
    end else if (p == ufg_pkg::OffIpSum || p == ufg_pkg::OffIpSum + 11'd1) begin
      region = ufg_pkg::RegIpSum;
      rel    = p - ufg_pkg::OffIpSum;
    end else if (p == ufg_pkg::OffIpLen || p == ufg_pkg::OffIpLen + 11'd1) begin
      region = ufg_pkg::RegIpLen;
      rel    = p - ufg_pkg::OffIpLen;
    end else begin
      region = ufg_pkg::RegConst;
      rel    = '0;
      if (p == ufg_pkg::OffEthType) begin
        cbyte = ufg_pkg::EtherTypeIpv4[15:8];
      end else if (p == ufg_pkg::OffEthType + 11'd1) begin
        cbyte = ufg_pkg::EtherTypeIpv4[7:0];
      end else if (p == ufg_pkg::EthHdrBytes) begin
        cbyte = ufg_pkg::IpVerIhl;
      end else if (p == ufg_pkg::EthHdrBytes + 11'd1) begin
        cbyte = ufg_pkg::TosLowDelay;
      end else if (p == ufg_pkg::OffIpFlags) begin
        cbyte = ufg_pkg::DontFragment[15:8];
      end else if (p == ufg_pkg::OffIpTtl) begin
        cbyte = ufg_pkg::DefaultTtl;
      end else if (p == ufg_pkg::OffIpProto) begin
        cbyte = ufg_pkg::UdpProto;
      end
    end
  end

  always_comb begin
    push_data_o.region = region;
    push_data_o.sel    = rel[2:0];
    push_data_o.cbyte  = cbyte;
    push_data_o.offset = p;
    push_data_o.last   = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
    end
  end

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && last |=> pos_q == '0)
    else $error("position did not return to zero after the final byte");

  a_pos_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && !last && (p_inc < {1'b0, len_i}) |=> pos_q == $past(p_inc[ufg_pkg::LenW-1:0]))
    else $error("position did not advance by one byte");

  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && restart_i |-> push_data_o.offset == '0)
    else $error("restart did not start at byte zero");

endmodule

>>> src/ufg_queue.sv
// Short queue between the front and back ends of the UDP frame generator.
// Registered entries with head and tail pointers; depends on ufg_pkg.
module ufg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ufg_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output ufg_pkg::entry_t head_data_o
);

  localparam int Depth = ufg_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ufg_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from an empty queue");

endmodule

>>> src/ufg_csum.sv
// Checksum pipeline of the UDP frame generator: IPv4 header and UDP checksums
// computed over four stages from the configuration at frame start. Depends on ufg_pkg.
module ufg_csum (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ufg_pkg::cfg_t cfg_i,
  output logic [15:0]   ip_sum_o,
  output logic [15:0]   udp_sum_o
);

  // Stage 1 inputs, taken from the live configuration.
  logic [ufg_pkg::LenW-1:0] pay;
  logic [9:0]               pairs;
  logic [9:0]               n0, n1;
  logic [15:0]              w0, w1;
  logic [7:0]               odd_byte;

  logic                     v1_q, v2_q, v3_q;
  logic [17:0]              addr_q;
  logic [25:0]              prod0_q, prod1_q;
  logic [17:0]              misc_q;
  logic [ufg_pkg::LenW-1:0] ip_len_q, ulen_q;
  logic                     on1_q, on2_q, on3_q;

  logic [26:0]              udp_a_q;
  logic [20:0]              udp_b_q;
  logic [19:0]              ip_tot_q;
  logic [27:0]              udp_tot_q;

  logic [15:0]              ip_sum_q, udp_sum_q;
  logic [15:0]              udp_fold;

  always_comb begin
    pay      = cfg_i.len - ufg_pkg::OffPayload;
    pairs    = pay[ufg_pkg::LenW-1:1];
    n0       = 10'((11'(pairs) + 11'd1) >> 1);
    n1       = pairs >> 1;
    w0       = {cfg_i.seed[7:0], cfg_i.seed[15:8]};
    w1       = {cfg_i.seed[23:16], cfg_i.seed[31:24]};
    // An odd payload ends on one seed byte that is summed as the high half.
    odd_byte = pay[0] ? cfg_i.seed[{cfg_i.len[1:0] + 2'd1, 3'b000} +: 8] : 8'h00;
  end

  assign udp_fold = ~ufg_pkg::fold16(udp_tot_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      addr_q   <= 18'(cfg_i.src_ip[31:16]) + 18'(cfg_i.src_ip[15:0])
                + 18'(cfg_i.dst_ip[31:16]) + 18'(cfg_i.dst_ip[15:0]);
      prod0_q  <= 26'(n0) * 26'(w0);
      prod1_q  <= 26'(n1) * 26'(w1);
      misc_q   <= 18'(cfg_i.ports[31:16]) + 18'(cfg_i.ports[15:0]) + {2'b00, odd_byte, 8'h00};
      ip_len_q <= cfg_i.len - ufg_pkg::EthHdrBytes;
      ulen_q   <= cfg_i.len - ufg_pkg::EthIpBytes;
      on1_q    <= cfg_i.csum_on;
    end
    if (v1_q) begin
      udp_a_q  <= 27'(prod0_q) + 27'(prod1_q);
      udp_b_q  <= 21'(ufg_pkg::UdpProto) + 21'({ulen_q, 1'b0}) + 21'(addr_q) + 21'(misc_q);
      ip_tot_q <= ufg_pkg::IpFixedSum + 20'(ip_len_q) + 20'(addr_q);
      on2_q    <= on1_q;
    end
    if (v2_q) begin
      udp_tot_q <= 28'(udp_a_q) + 28'(udp_b_q);
      on3_q     <= on2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      ip_sum_q  <= '0;
      udp_sum_q <= '0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v2_q) begin
        ip_sum_q <= ~ufg_pkg::fold16(28'(ip_tot_q));
      end
      if (v3_q) begin
        if (!on3_q) begin
          udp_sum_q <= '0;
        end else if (udp_fold == '0) begin
          udp_sum_q <= 16'hFFFF;
        end else begin
          udp_sum_q <= udp_fold;
        end
      end
    end
  end

  assign ip_sum_o  = ip_sum_q;
  assign udp_sum_o = udp_sum_q;

endmodule

>>> src/ufg_back.sv
// Back end of the UDP frame generator: takes classified entries from the queue,
// forms the byte from configuration and checksums, and holds it in the output register.
// Depends on ufg_pkg.
module ufg_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  ufg_pkg::entry_t          head_data_i,
  output logic                     pop_o,
  input  ufg_pkg::cfg_t            cfg_i,
  input  logic [15:0]              ip_sum_i,
  input  logic [15:0]              udp_sum_i,
  output logic                     csum_start_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               frame_byte_o,
  output logic [ufg_pkg::LenW-1:0] byte_offset_o,
  output logic                     last_byte_o
);

  logic                     out_valid_q;
  logic [7:0]               byte_q, byte_d;
  logic [ufg_pkg::LenW-1:0] offset_q;
  logic                     last_q;
  logic [ufg_pkg::LenW-1:0] ip_len, ulen;
  logic [2:0]               mac_idx;
  logic [1:0]               ip_idx;
  logic                     lo;

  assign pop_o        = head_valid_i && (!out_valid_q || !out_stall_i);
  assign csum_start_o = pop_o && (head_data_i.offset == '0);

  always_comb begin
    ip_len  = cfg_i.len - ufg_pkg::EthHdrBytes;
    ulen    = cfg_i.len - ufg_pkg::EthIpBytes;
    mac_idx = 3'd5 - head_data_i.sel;
    ip_idx  = 2'd3 - head_data_i.sel[1:0];
    lo      = head_data_i.sel[0];
    case (head_data_i.region)
      ufg_pkg::RegDstMac:  byte_d = cfg_i.dst_mac[{mac_idx, 3'b000} +: 8];
      ufg_pkg::RegSrcMac:  byte_d = cfg_i.src_mac[{mac_idx, 3'b000} +: 8];
      ufg_pkg::RegConst:   byte_d = head_data_i.cbyte;
      ufg_pkg::RegIpLen:   byte_d = lo ? ip_len[7:0] : 8'(ip_len[ufg_pkg::LenW-1:8]);
      ufg_pkg::RegIpSum:   byte_d = lo ? ip_sum_i[7:0] : ip_sum_i[15:8];
      ufg_pkg::RegSrcIp:   byte_d = cfg_i.src_ip[{ip_idx, 3'b000} +: 8];
      ufg_pkg::RegDstIp:   byte_d = cfg_i.dst_ip[{ip_idx, 3'b000} +: 8];
      // Source port goes first on the wire, from the low half of the pair.
      ufg_pkg::RegPorts:   byte_d = cfg_i.ports[{head_data_i.sel[1], ~lo, 3'b000} +: 8];
      ufg_pkg::RegUdpLen:  byte_d = lo ? ulen[7:0] : 8'(ulen[ufg_pkg::LenW-1:8]);
      ufg_pkg::RegUdpSum:  byte_d = lo ? udp_sum_i[7:0] : udp_sum_i[15:8];
      ufg_pkg::RegPayload: byte_d = cfg_i.seed[{head_data_i.sel[1:0], 3'b000} +: 8];
      default:             byte_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= byte_d;
      offset_q <= head_data_i.offset;
      last_q   <= head_data_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = byte_q;
  assign byte_offset_o = offset_q;
  assign last_byte_o   = last_q;

endmodule

>>> src/udp_frame_generator.sv
// UDP frame generator: one Ethernet/IPv4/UDP frame byte per accepted request beat.
// Each accepted request is held in a queue entry, and its byte then goes into the output register.
// Throughput is one byte per cycle while the output is not stalled, through the single output register.
// Both checksums come from a four-stage pipeline started at byte 0, done before byte 24.
// Reset clears the position, checksums and control; configuration takes its reset values.
module udp_frame_generator #(
  parameter int MAX_FRAME_BYTES = ufg_pkg::MaxFrameBytes
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [47:0]              cfg_wdata_i,
  // Request channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     restart_i,
  // Byte channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               frame_byte_o,
  output logic [ufg_pkg::LenW-1:0] byte_offset_o,
  output logic                     last_byte_o
);

  // Configuration registers.
  logic [47:0]              dst_mac_q, src_mac_q;
  logic [31:0]              dst_ip_q, src_ip_q, ports_q, seed_q;
  logic [ufg_pkg::LenW-1:0] frame_len_q;
  logic                     csum_on_q;

  logic [ufg_pkg::LenW-1:0] eff_len;
  ufg_pkg::cfg_t            cfg;

  logic                     push, q_full, pop, head_valid, csum_start;
  ufg_pkg::entry_t          push_data, head_data;
  logic [15:0]              ip_sum, udp_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_mac_q   <= '0;
      src_mac_q   <= '0;
      dst_ip_q    <= '0;
      src_ip_q    <= '0;
      ports_q     <= '0;
      frame_len_q <= ufg_pkg::ResetFrameLength;
      seed_q      <= '0;
      csum_on_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ufg_pkg::CfgDstMac:   dst_mac_q   <= cfg_wdata_i;
        ufg_pkg::CfgSrcMac:   src_mac_q   <= cfg_wdata_i;
        ufg_pkg::CfgDstIp:    dst_ip_q    <= cfg_wdata_i[31:0];
        ufg_pkg::CfgSrcIp:    src_ip_q    <= cfg_wdata_i[31:0];
        ufg_pkg::CfgPorts:    ports_q     <= cfg_wdata_i[31:0];
        ufg_pkg::CfgFrameLen: frame_len_q <= cfg_wdata_i[ufg_pkg::LenW-1:0];
        ufg_pkg::CfgSeed:     seed_q      <= cfg_wdata_i[31:0];
        ufg_pkg::CfgCsumOn:   csum_on_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The frame length is saturated into the legal range before anyone sees it.
  always_comb begin
    if (frame_len_q < ufg_pkg::LenW'(ufg_pkg::MinFrameBytes)) begin
      eff_len = ufg_pkg::LenW'(ufg_pkg::MinFrameBytes);
    end else if (int'(frame_len_q) > MAX_FRAME_BYTES) begin
      eff_len = ufg_pkg::LenW'(MAX_FRAME_BYTES);
    end else begin
      eff_len = frame_len_q;
    end
  end

  always_comb begin
    cfg.dst_mac = dst_mac_q;
    cfg.src_mac = src_mac_q;
    cfg.dst_ip  = dst_ip_q;
    cfg.src_ip  = src_ip_q;
    cfg.ports   = ports_q;
    cfg.seed    = seed_q;
    cfg.csum_on = csum_on_q;
    cfg.len     = eff_len;
  end

  // The request side stalls only when the queue is full, never on the state
  // of the output register directly.
  assign in_stall_o = q_full;

  ufg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .restart_i   (restart_i),
    .len_i       (eff_len),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ufg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  // Checksums start when byte 0 leaves the queue, so a newer frame can never
  // overwrite them while bytes of the older frame still wait to be formed.
  ufg_csum u_csum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (csum_start),
    .cfg_i     (cfg),
    .ip_sum_o  (ip_sum),
    .udp_sum_o (udp_sum)
  );

  ufg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_data_i   (head_data),
    .pop_o         (pop),
    .cfg_i         (cfg),
    .ip_sum_i      (ip_sum),
    .udp_sum_i     (udp_sum),
    .csum_start_o  (csum_start),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_byte_o  (frame_byte_o),
    .byte_offset_o (byte_offset_o),
    .last_byte_o   (last_byte_o)
  );

endmodule
